@@ rtl/core/gbc_pkg.sv @@
// gbc_pkg: shared types and constants of the gamma-corrected blend cache.
// Sizes, word layouts, operation codes, FSM states and control structs.
// Depends on nothing; every other file imports it.
package gbc_pkg;

   // sizing
   localparam int SHADES           = 16;
   localparam int KEYS             = 256;
   localparam int GAMMA_EXTRA_BITS = 2;

   // fixed-point and color layout
   localparam int FRAC_BITS = 10;
   localparam int CHAN_W    = 8;
   localparam int LANES     = 3;
   localparam int COLOR_W   = 32;

   // ramps
   localparam int FWD_DEPTH = 256;
   localparam int FWD_AW    = 8;
   localparam int FWD_W     = CHAN_W + GAMMA_EXTRA_BITS;
   localparam int INV_DEPTH = 256 << GAMMA_EXTRA_BITS;
   localparam int INV_AW    = FWD_W;

   // per-channel step arithmetic: signed truncating divide by SHADES-1
   // done as a reciprocal multiply on the magnitude
   localparam int MAG_W      = FWD_W + FRAC_BITS;
   localparam int ACC_W      = MAG_W + 1;
   localparam int STEP_DIV   = SHADES - 1;
   localparam int STEP_LOG   = $clog2(STEP_DIV);
   localparam int STEP_SHIFT = MAG_W + STEP_LOG;
   localparam int RECIP_W    = MAG_W + 2;
   localparam int PROD_W     = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] STEP_RECIP =
      RECIP_W'(((64'd1 << STEP_SHIFT) + 64'(STEP_DIV - 1)) / 64'(STEP_DIV));

   // hash: (back ^ fore ^ mix) mod (KEYS-1), one byte per cycle
   localparam logic [31:0] HASH_MIX = 32'h5555_5555;
   localparam int SLOT_W     = $clog2(KEYS);
   localparam int HASH_MOD   = KEYS - 1;
   localparam int HASH_W     = 32;
   localparam int HASH_DIGIT = 8;
   localparam int HASH_STEPS = HASH_W / HASH_DIGIT;
   localparam int HCNT_W     = $clog2(HASH_STEPS + 1);

   // gradient store
   localparam int CELL_W  = $clog2(SHADES);
   localparam int CELLS   = KEYS * SHADES;
   localparam int CADDR_W = $clog2(CELLS);

   typedef enum logic [1:0] {
      OP_BLEND      = 2'd0,
      OP_FWD_WR     = 2'd1,
      OP_INV_WR     = 2'd2,
      OP_INVALIDATE = 2'd3
   } gbc_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_CHECK,
      ST_FILL,
      ST_DRAIN,
      ST_READ,
      ST_RESP
   } gbc_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  table_index;
      logic [9:0]  table_value;
      logic [31:0] background;
      logic [31:0] foreground;
      logic [3:0]  shade;
   } gbc_req_type;

   typedef struct packed {
      logic [31:0] color;
      logic        hit;
   } gbc_rsp_type;

   typedef struct packed {
      logic              fwd_en;
      logic [FWD_AW-1:0] fwd_addr;
      logic [FWD_W-1:0]  fwd_data;
      logic              inv_en;
      logic [INV_AW-1:0] inv_addr;
      logic [CHAN_W-1:0] inv_data;
   } gbc_ramp_wr_type;

   typedef struct packed {
      logic load;
      logic adv;
   } gbc_lane_ctl_type;

   typedef struct packed {
      logic               wr_en;
      logic               wr_back;
      logic [CADDR_W-1:0] wr_addr;
      logic               rd_en;
      logic [CADDR_W-1:0] rd_addr;
   } gbc_cell_ctl_type;

endpackage

@@ rtl/core/gamma_correct_blend_cache.sv @@
// gamma_correct_blend_cache: top level of the gamma-corrected blend cache.
// Control FSM, key store and valid bits; uses gbc_hash, gbc_lane, gbc_cells, gbc_pkg.
//
// Usage: one word is taken on start while busy is low. Ramp writes and
// invalidate complete at the accepting edge and give no result; busy stays
// low. A blend lookup raises busy and later returns one word on rsp_data,
// marked by rsp_valid for exactly one cycle; it must be taken then, there
// is no back-pressure. The next word may be started in that result cycle.
// A lookup is paced by the slot hash, which reduces one key byte per cycle,
// and on a miss also by the cell store's single write port, which takes one
// gradient cell per cycle while the three channel lanes run in parallel.
// Invalidate clears all valid bits at once; there is no clearing pass.
// Both ramps must be loaded before lookups that use their entries.
module gamma_correct_blend_cache (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  gbc_pkg::gbc_req_type  req_data,
   output logic                  rsp_valid,
   output gbc_pkg::gbc_rsp_type  rsp_data
);
   import gbc_pkg::*;

   gbc_state_type state_ff, state_in;

   gbc_req_type        req_ff;
   logic [KEYS-1:0]    valid_ff;
   logic [63:0]        key_mem [KEYS];
   logic [63:0]        key_rd_ff;
   logic [CADDR_W-1:0] base_ff;
   logic [CELL_W-1:0]  fill_n_ff;
   logic [CADDR_W-1:0] fill_addr_ff;
   logic               fill_pend_ff, fill_pend_in;
   logic               hit_ff;

   logic              accept;
   logic              hash_load;
   logic [SLOT_W-1:0] slot;
   logic              hash_last;
   logic              hit_now;
   logic              fill_last;
   logic              clear_all;
   logic              valid_set;
   logic              key_wr;
   logic [CELL_W-1:0] shade_sat;

   gbc_ramp_wr_type   ramp_wr;
   gbc_lane_ctl_type  lane_ctl;
   gbc_cell_ctl_type  cell_ctl;
   logic [LANES-1:0][CHAN_W-1:0] lane_byte;
   logic [31:0]       cell_word;

   // result word sits in the cell read register; a new item may enter then
   assign busy   = !(state_ff == ST_IDLE || state_ff == ST_RESP);
   assign accept = start && !busy;

   // key compare against the probed entry
   assign hit_now   = valid_ff[slot] && (key_rd_ff == {req_ff.background, req_ff.foreground});
   assign fill_last = (fill_n_ff == CELL_W'(SHADES - 1));

   // shade beyond the gradient saturates to the last cell
   always_comb begin
      if (32'(req_ff.shade) >= 32'(SHADES)) begin
         shade_sat = CELL_W'(SHADES - 1);
      end else begin
         shade_sat = CELL_W'(req_ff.shade);
      end
   end

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (accept && req_data.op == OP_BLEND) begin
               state_in = ST_HASH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HASH: begin
            if (hash_last) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = hit_now ? ST_READ : ST_FILL;
         end
         ST_FILL: begin
            if (fill_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_READ;
         ST_READ:  state_in = ST_RESP;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hash_load    = accept && req_data.op == OP_BLEND;
      clear_all    = accept && req_data.op == OP_INVALIDATE;

      ramp_wr.fwd_en   = accept && req_data.op == OP_FWD_WR
                         && req_data.table_index < 10'(FWD_DEPTH);
      ramp_wr.fwd_addr = req_data.table_index[FWD_AW-1:0];
      ramp_wr.fwd_data = FWD_W'(req_data.table_value);
      ramp_wr.inv_en   = accept && req_data.op == OP_INV_WR
                         && 32'(req_data.table_index) < 32'(INV_DEPTH);
      ramp_wr.inv_addr = INV_AW'(req_data.table_index);
      ramp_wr.inv_data = req_data.table_value[CHAN_W-1:0];

      valid_set    = 1'b0;
      key_wr       = 1'b0;
      lane_ctl     = '0;
      fill_pend_in = 1'b0;
      rsp_valid    = 1'b0;

      cell_ctl.wr_en   = fill_pend_ff;
      cell_ctl.wr_back = 1'b0;
      cell_ctl.wr_addr = fill_addr_ff;
      cell_ctl.rd_en   = 1'b0;
      cell_ctl.rd_addr = base_ff + CADDR_W'(shade_sat);

      unique case (state_ff)
         ST_CHECK: begin
            if (!hit_now) begin
               // miss: claim the entry, write cell 0, prime the lanes
               valid_set        = 1'b1;
               key_wr           = 1'b1;
               lane_ctl.load    = 1'b1;
               cell_ctl.wr_en   = 1'b1;
               cell_ctl.wr_back = 1'b1;
               cell_ctl.wr_addr = base_ff;
            end
         end
         ST_FILL: begin
            lane_ctl.adv = 1'b1;
            fill_pend_in = 1'b1;
         end
         ST_READ: cell_ctl.rd_en = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         fill_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_pend_ff <= fill_pend_in;
         if (clear_all) begin
            valid_ff <= '0;
         end else if (valid_set) begin
            valid_ff[slot] <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------ datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_PROBE) begin
         base_ff <= CADDR_W'(slot) * CADDR_W'(SHADES);
      end
      if (state_ff == ST_CHECK) begin
         hit_ff    <= hit_now;
         fill_n_ff <= CELL_W'(1);
      end else if (state_ff == ST_FILL) begin
         fill_n_ff <= fill_n_ff + CELL_W'(1);
      end
      // cell n is written the cycle after its lanes look it up
      fill_addr_ff <= base_ff + CADDR_W'(fill_n_ff);
   end

   // key store: one write, one registered read
   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_mem[slot] <= {req_ff.background, req_ff.foreground};
      end
      if (state_ff == ST_PROBE) begin
         key_rd_ff <= key_mem[slot];
      end
   end

   gbc_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .load     (hash_load),
      .key_word (req_data.background ^ req_data.foreground ^ HASH_MIX),
      .slot     (slot),
      .last     (hash_last)
   );

   // lane 0 blue, lane 1 green, lane 2 red
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      gbc_lane u_lane (
         .clock     (clock),
         .ramp_wr   (ramp_wr),
         .back_c    (req_ff.background[k*CHAN_W +: CHAN_W]),
         .fore_c    (req_ff.foreground[k*CHAN_W +: CHAN_W]),
         .ctl       (lane_ctl),
         .cell_byte (lane_byte[k])
      );
   end

   gbc_cells u_cells (
      .clock     (clock),
      .ctl       (cell_ctl),
      .back      (req_ff.background),
      .lane_byte (lane_byte),
      .rd_data   (cell_word)
   );

   assign rsp_data.color = cell_word;
   assign rsp_data.hit   = hit_ff;

   // ---------------------------------------------------------- assertions
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_last_slot_unused: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (slot != SLOT_W'(KEYS - 1)))
      else $error("hash produced the reserved last slot");

   a_miss_claims_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !hit_now) |=> valid_ff[slot])
      else $error("refilled entry not marked valid");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cell_ctl.wr_en && cell_ctl.rd_en))
      else $error("cell store written and read in the same cycle");

endmodule

@@ rtl/core/gbc_hash.sv @@
// gbc_hash: iterative slot hash, (key word) mod (KEYS-1), one byte per cycle.
// Restoring reduction MSB first.
// Depends on gbc_pkg.
module gbc_hash (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [31:0]                key_word,
   output logic [gbc_pkg::SLOT_W-1:0] slot,
   output logic                       last
);
   import gbc_pkg::*;

   logic [HASH_W-1:0] x_ff, x_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [HCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      logic [SLOT_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < HASH_DIGIT; i++) begin
         r = {r[SLOT_W-1:0], x_ff[HASH_W-1-i]};
         if (r >= (SLOT_W+1)'(HASH_MOD)) begin
            r = r - (SLOT_W+1)'(HASH_MOD);
         end
      end
      x_in   = x_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (load) begin
         x_in   = key_word;
         rem_in = '0;
         cnt_in = HCNT_W'(HASH_STEPS);
      end else if (cnt_ff != '0) begin
         x_in   = x_ff << HASH_DIGIT;
         rem_in = r[SLOT_W-1:0];
         cnt_in = cnt_ff - HCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      rem_ff <= rem_in;
   end

   assign slot = rem_ff;
   assign last = (cnt_ff == HCNT_W'(1));

endmodule

@@ rtl/core/gbc_lane.sv @@
// gbc_lane: one color channel of the gradient fill.
// Holds its own copy of both ramps, derives the gamma-space step and walks cells.
// Depends on gbc_pkg.
module gbc_lane (
   input  logic                            clock,
   input  gbc_pkg::gbc_ramp_wr_type        ramp_wr,
   input  logic [gbc_pkg::CHAN_W-1:0]      back_c,
   input  logic [gbc_pkg::CHAN_W-1:0]      fore_c,
   input  gbc_pkg::gbc_lane_ctl_type       ctl,
   output logic [gbc_pkg::CHAN_W-1:0]      cell_byte
);
   import gbc_pkg::*;

   logic [FWD_W-1:0]  fwd_mem [FWD_DEPTH];
   logic [CHAN_W-1:0] inv_mem [INV_DEPTH];

   logic [FWD_W-1:0]         fa_ff, fb_ff;
   logic signed [ACC_W-1:0]  a_ff, a_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in, neg2_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic signed [ACC_W-1:0]  step_ff, step_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [INV_AW-1:0]        pos;
   logic [CHAN_W-1:0]        inv_ff;

   // ramp ports: one write, two reads on the forward copy, one on the inverse
   always_ff @(posedge clock) begin
      if (ramp_wr.fwd_en) begin
         fwd_mem[ramp_wr.fwd_addr] <= ramp_wr.fwd_data;
      end
      fa_ff <= fwd_mem[back_c];
      fb_ff <= fwd_mem[fore_c];
   end

   always_ff @(posedge clock) begin
      if (ramp_wr.inv_en) begin
         inv_mem[ramp_wr.inv_addr] <= ramp_wr.inv_data;
      end
      inv_ff <= inv_mem[pos];
   end

   // endpoints in gamma space, difference split into sign and magnitude
   always_comb begin
      logic signed [ACC_W-1:0] b_v;
      logic signed [ACC_W-1:0] d_v;
      a_in   = $signed({1'b0, fa_ff, {FRAC_BITS{1'b0}}});
      b_v    = $signed({1'b0, fb_ff, {FRAC_BITS{1'b0}}});
      d_v    = b_v - a_in;
      neg_in = d_v[ACC_W-1];
      mag_in = neg_in ? MAG_W'(-d_v) : MAG_W'(d_v);
   end

   // quotient by reciprocal, sign restored (truncation toward zero)
   always_comb begin
      logic [MAG_W-1:0] q;
      q       = MAG_W'(prod_ff >> STEP_SHIFT);
      step_in = neg2_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = a_ff + step_ff;
      end else if (ctl.adv) begin
         acc_in = acc_ff + step_ff;
      end
      if (acc_ff < 0) begin
         pos = '0;
      end else begin
         pos = acc_ff[MAG_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= PROD_W'(mag_ff) * PROD_W'(STEP_RECIP);
      neg2_ff <= neg_ff;
      step_ff <= step_in;
      acc_ff  <= acc_in;
   end

   assign cell_byte = inv_ff;

endmodule

@@ rtl/core/gbc_cells.sv @@
// gbc_cells: gradient cell store and lane merge.
// Packs the three lane bytes into an RGB word, writes one cell per cycle, registered read.
// Depends on gbc_pkg.
module gbc_cells (
   input  logic                                   clock,
   input  gbc_pkg::gbc_cell_ctl_type              ctl,
   input  logic [31:0]                            back,
   input  logic [gbc_pkg::LANES-1:0][gbc_pkg::CHAN_W-1:0] lane_byte,
   output logic [31:0]                            rd_data
);
   import gbc_pkg::*;

   logic [COLOR_W-1:0] cell_mem [CELLS];
   logic [COLOR_W-1:0] wr_data;
   logic [COLOR_W-1:0] rd_ff;

   // cell 0 is the background word as is; others are 0RGB
   assign wr_data = ctl.wr_back ? back : COLOR_W'(lane_byte);

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         cell_mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= cell_mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

@@ test/gamma_correct_blend_cache_tb.sv @@
// Self-checking bench for gamma_correct_blend_cache: loads both gamma ramps,
// then drives directed and random lookups, ramp writes and invalidates.
// Depends on gbc_pkg and the block's RTL; keeps its own shadow of the cache.
`timescale 1ns / 100ps

module gamma_correct_blend_cache_tb;
   import gbc_pkg::*;

   localparam int QUIET_LIMIT = 2000;  // cycles with no word moving
   localparam int GAP_CAP     = 40;    // longest sender pause
   localparam int POOL        = 24;    // key pairs that get reused for hits
   localparam int POOL_W      = $clog2(POOL);
   localparam int REPORT_MAX  = 10;
   localparam int TAIL_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   gbc_req_type req_data;
   logic        rsp_valid;
   gbc_rsp_type rsp_data;

   gamma_correct_blend_cache dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // shadow copy of the cache and ramps
   logic [KEYS-1:0]    shadow_valid;
   logic [31:0]        shadow_back  [KEYS];
   logic [31:0]        shadow_fore  [KEYS];
   logic [31:0]        shadow_cells [KEYS][SHADES];
   logic [FWD_W-1:0]   shadow_fwd   [FWD_DEPTH];
   logic [CHAN_W-1:0]  shadow_inv   [INV_DEPTH];

   gbc_rsp_type expected_words[$];   // lookup results still owed by the block

   logic [31:0] pool_back [POOL];
   logic [31:0] pool_fore [POOL];

   int err_count    = 0;
   int idle_pct     = 0;   // chance in 100 that the sender pauses after a word or stays paused
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      err_count++;
      if (err_count <= REPORT_MAX)
         $display("%t %s", $realtime, msg);
   endfunction

   // One channel of gradient step n: forward ramp into linear light, a signed
   // step truncated toward zero, back out through the inverse ramp.
   function automatic logic [CHAN_W-1:0] gradient_channel(input logic [7:0] back_c,
                                                          input logic [7:0] fore_c,
                                                          input int n);
      int lo, hi, stride, acc;
      lo = int'(shadow_fwd[back_c]) << FRAC_BITS;
      hi = int'(shadow_fwd[fore_c]) << FRAC_BITS;
      stride = (hi - lo) / (SHADES - 1);
      acc = lo + stride * n;
      if (acc < 0)
         acc = 0;
      return shadow_inv[INV_AW'((acc >> FRAC_BITS) & (INV_DEPTH - 1))];
   endfunction

   // Apply one accepted word to the shadow; a lookup queues its result.
   function automatic void predict_word(input gbc_req_type w);
      logic [31:0]       hashed;
      logic [SLOT_W-1:0] slot;
      logic [CELL_W-1:0] shade_sel;
      gbc_rsp_type       want;
      case (gbc_op_type'(w.op))
         OP_FWD_WR: begin
            // index past the forward ramp is dropped, not wrapped
            if (w.table_index < FWD_DEPTH)
               shadow_fwd[w.table_index[FWD_AW-1:0]] =
                  FWD_W'(w.table_value & (INV_DEPTH - 1));
         end
         OP_INV_WR: begin
            if (w.table_index < INV_DEPTH)
               shadow_inv[w.table_index] = w.table_value[CHAN_W-1:0];
         end
         OP_INVALIDATE: begin
            shadow_valid = '0;
         end
         OP_BLEND: begin
            // last slot is never produced by the modulo
            hashed = w.background ^ w.foreground ^ HASH_MIX;
            slot = SLOT_W'(hashed % 32'(KEYS - 1));
            want.hit = shadow_valid[slot] && shadow_back[slot] == w.background
                       && shadow_fore[slot] == w.foreground;
            if (!want.hit) begin
               shadow_valid[slot] = 1'b1;
               shadow_back[slot] = w.background;
               shadow_fore[slot] = w.foreground;
               // step 0 keeps the whole background word, top byte included
               shadow_cells[slot][0] = w.background;
               for (int n = 1; n < SHADES; n++)
                  shadow_cells[slot][CELL_W'(n)] = {8'h00,
                     gradient_channel(w.background[23:16], w.foreground[23:16], n),
                     gradient_channel(w.background[15:8], w.foreground[15:8], n),
                     gradient_channel(w.background[7:0], w.foreground[7:0], n)};
            end
            // a shade past the gradient saturates at its last step
            if (32'(w.shade) > 32'(SHADES - 1))
               shade_sel = CELL_W'(SHADES - 1);
            else
               shade_sel = CELL_W'(w.shade);
            want.color = shadow_cells[slot][shade_sel];
            expected_words.push_back(want);
         end
      endcase
   endfunction

   function automatic gbc_req_type make_word(input gbc_op_type op, input logic [9:0] idx,
                                             input logic [9:0] val, input logic [31:0] back,
                                             input logic [31:0] fore, input logic [3:0] shade);
      gbc_req_type w;
      w.op = op;
      w.table_index = idx;
      w.table_value = val;
      w.background = back;
      w.foreground = fore;
      w.shade = shade;
      return w;
   endfunction

   // Present one word, hold it until taken, predict it, then maybe pause.
   // start stays high across back-to-back words; it only drops for a pause.
   task automatic send_word(input gbc_req_type w);
      int gap;
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      predict_word(w);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         gap = 0;
         do begin
            @(posedge clock);
            gap++;
         end while (gap < GAP_CAP && $urandom_range(99) < idle_pct);
      end
   endtask

   // unused fields carry random bits so they get toggled too
   task automatic blend(input logic [31:0] back, input logic [31:0] fore,
                        input logic [3:0] shade);
      send_word(make_word(OP_BLEND, 10'($urandom), 10'($urandom), back, fore, shade));
   endtask

   task automatic write_fwd(input logic [9:0] idx, input logic [9:0] val);
      send_word(make_word(OP_FWD_WR, idx, val, $urandom, $urandom, 4'($urandom)));
   endtask

   task automatic write_inv(input logic [9:0] idx, input logic [9:0] val);
      send_word(make_word(OP_INV_WR, idx, val, $urandom, $urandom, 4'($urandom)));
   endtask

   task automatic invalidate();
      send_word(make_word(OP_INVALIDATE, 10'($urandom), 10'($urandom), $urandom,
                          $urandom, 4'($urandom)));
   endtask

   // Sender holds off until every owed result is back.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   // Every ramp entry gets written before any lookup, so no refill reads
   // an unwritten entry. Ends of the forward ramp pinned to its extremes.
   task automatic test_ramp_load();
      for (int i = 0; i < FWD_DEPTH; i++)
         write_fwd(10'(i), (i == 0) ? 10'd0 : (i == FWD_DEPTH - 1) ? 10'h3FF
                                       : 10'($urandom_range(1023)));
      for (int i = 0; i < INV_DEPTH; i++)
         write_inv(10'(i), 10'($urandom_range(1023)));
   endtask

   // Extreme colors: full rising and falling gradients, flat gradient.
   task automatic test_edge_colors();
      logic [31:0] same;
      same = $urandom;
      blend(32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
      blend(32'h0000_0000, 32'hFFFF_FFFF, 4'd15);
      blend(32'hFFFF_FFFF, 32'h0000_0000, 4'd15);
      blend(32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
      blend(same, same, 4'd9);
   endtask

   // Distinct keys landing in one slot must evict each other.
   task automatic test_key_collisions();
      logic [31:0] back, fore, mask;
      back = $urandom;
      fore = $urandom;
      mask = $urandom | 32'h1;
      blend(back, fore, 4'd3);
      blend(back ^ mask, fore ^ mask, 4'd3);   // same xor, same slot
      blend(back, fore, 4'd12);                // evicted, misses again
      // hashed values 3 and 258 meet under the modulo
      blend(HASH_MIX ^ 32'd3, 32'd0, 4'd1);
      blend(HASH_MIX ^ 32'd258, 32'd0, 4'd1);
      blend(HASH_MIX ^ 32'd3, 32'd0, 4'd1);
      // all-ones and zero hashed values both map to slot 0
      blend(~HASH_MIX, 32'd0, 4'd2);
      blend(HASH_MIX, 32'd0, 4'd2);
   endtask

   // Out-of-range forward indexes are dropped; 1023 would alias to 255.
   task automatic test_ramp_write_ranges();
      write_fwd(10'd256, 10'($urandom_range(1023)));
      write_fwd(10'd1023, 10'($urandom_range(1023)));
      write_fwd(10'd255, 10'h3FF);
      write_fwd(10'd0, 10'd0);
      write_inv(10'd1023, 10'h3FF);
      write_inv(10'd0, 10'd0);
      invalidate();
      blend(32'h0000_0000, 32'h00FF_FFFF, 4'd15);
   endtask

   // Invalidate forces a refill of a pair that hit just before.
   task automatic test_invalidate();
      blend(pool_back[0], pool_fore[0], 4'd5);
      blend(pool_back[0], pool_fore[0], 4'd6);
      invalidate();
      blend(pool_back[0], pool_fore[0], 4'd7);
      blend(pool_back[0], pool_fore[0], 4'd8);
   endtask

   // Mostly lookups from a reused pool so hits dominate, with slot
   // collisions, fresh pairs, ramp rewrites and the odd invalidate.
   task automatic test_random_traffic(input int words);
      int                pick;
      logic [POOL_W-1:0] k;
      logic [31:0]       mask;
      for (int i = 0; i < words; i++) begin
         pick = $urandom_range(99);
         k = POOL_W'($urandom_range(POOL - 1));
         if (pick < 2) begin
            invalidate();
         end else if (pick < 8) begin
            write_fwd(($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                               : 10'($urandom_range(255)),
                      10'($urandom_range(1023)));
         end else if (pick < 14) begin
            write_inv(10'($urandom_range(1023)), 10'($urandom_range(1023)));
         end else if (pick < 18) begin
            pool_back[k] = $urandom;
            pool_fore[k] = $urandom;
            blend(pool_back[k], pool_fore[k], 4'($urandom_range(15)));
         end else if (pick < 30) begin
            mask = $urandom;
            blend(pool_back[k] ^ mask, pool_fore[k] ^ mask, 4'($urandom_range(15)));
         end else if (pick < 40) begin
            blend($urandom, $urandom, 4'($urandom_range(15)));
         end else begin
            blend(pool_back[k], pool_fore[k], 4'($urandom_range(15)));
         end
      end
   endtask

   // Result checker: each strobed word against the oldest owed result.
   always @(posedge clock) begin : check_words
      gbc_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            note_failure($sformatf("unexpected word color=%h hit=%b",
                                   rsp_data.color, rsp_data.hit));
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.color !== want.color)
               note_failure($sformatf("color mismatch: expected %h got %h",
                                      want.color, rsp_data.color));
            if (rsp_data.hit !== want.hit)
               note_failure($sformatf("hit mismatch: expected %b got %b",
                                      want.hit, rsp_data.hit));
         end
      end
   end

   // Watchdog: too long with no word accepted or returned ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      shadow_valid = '0;
      for (int i = 0; i < POOL; i++) begin
         pool_back[POOL_W'(i)] = $urandom;
         pool_fore[POOL_W'(i)] = $urandom;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_ramp_load();
      test_edge_colors();
      test_key_collisions();
      test_ramp_write_ranges();
      test_invalidate();

      // random traffic in sender-pause phases; full drain between them
      idle_pct = 0;
      test_random_traffic(36);
      drain_results();
      idle_pct = 82;
      test_random_traffic(36);
      drain_results();
      idle_pct = 17;
      test_random_traffic(36);
      drain_results();
      idle_pct = 0;
      test_random_traffic(36);
      drain_results();

      // let any stray strobe show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/gbc_pkg.sv
rtl/core/gbc_hash.sv
rtl/core/gbc_lane.sv
rtl/core/gbc_cells.sv
rtl/core/gamma_correct_blend_cache.sv
test/gamma_correct_blend_cache_tb.sv
